### rtl/lapsh_pkg.sv
// Types and constants shared by the 3x3 Laplacian sharpening block.
// No dependencies; lapsh_kernel, lapsh_out_queue and the top level import this package.
`timescale 1ns / 1ps

package lapsh_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W  = 8;
   localparam int COL_W  = 10;
   localparam int ROW_W  = 12;
   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
   localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
   localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);
   localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);
   localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
   localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_ROUND_MODE   = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             is_border;
      logic             last_of_run;
   } rsp_type;

   // Up to two words produced by one pixel, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

endpackage

### rtl/lapsh_line_ram.sv
// One line store: single write port, registered read port.
// A read at the address written in the same cycle returns the new data.
`timescale 1ns / 1ps

module lapsh_line_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lapsh_kernel.sv
// Sharpening arithmetic and result formatting for one pixel.
// Depends on lapsh_pkg for field widths and the push_type word pair.
`timescale 1ns / 1ps

module lapsh_kernel (
   input  logic [lapsh_pkg::PIX_W-1:0] up,
   input  logic [lapsh_pkg::PIX_W-1:0] left,
   input  logic [lapsh_pkg::PIX_W-1:0] mid,
   input  logic [lapsh_pkg::PIX_W-1:0] right,
   input  logic [lapsh_pkg::PIX_W-1:0] down,
   input  logic                        round_mode,
   input  logic [lapsh_pkg::PIX_W-1:0] pixel,
   input  logic [lapsh_pkg::ROW_W-1:0] row,
   input  logic [lapsh_pkg::COL_W-1:0] col,
   input  logic                        interior,
   input  logic                        border,
   output lapsh_pkg::push_type         push
);

   import lapsh_pkg::*;

   logic [11:0]      pos_sum;
   logic [11:0]      neg_sum;
   logic [11:0]      diff;
   logic [9:0]       quot;
   logic [PIX_W-1:0] sharp;
   rsp_type          intr_word;
   rsp_type          bord_word;

   always_comb begin
      pos_sum = {1'b0, mid, 3'b000};
      neg_sum = {4'b0, up} + {4'b0, left} + {4'b0, right} + {4'b0, down};
      diff    = pos_sum - neg_sum;
      quot    = {1'b0, diff[10:2]} + {9'b0, (round_mode && (diff[1:0] == 2'b11))};
      // Negative sum gives zero; large quotient saturates.
      if (pos_sum < neg_sum) begin
         sharp = '0;
      end else if (quot > 10'd255) begin
         sharp = 8'd255;
      end else begin
         sharp = quot[PIX_W-1:0];
      end
   end

   always_comb begin
      intr_word.pixel_out   = sharp;
      intr_word.out_row     = row - ROW_W'(1);
      intr_word.out_col     = col - COL_W'(1);
      intr_word.is_border   = 1'b0;
      intr_word.last_of_run = !border;

      bord_word.pixel_out   = pixel;
      bord_word.out_row     = row;
      bord_word.out_col     = col;
      bord_word.is_border   = 1'b1;
      bord_word.last_of_run = 1'b1;

      push.count = {1'b0, interior} + {1'b0, border};
      push.slot0 = interior ? intr_word : bord_word;
      push.slot1 = bord_word;
   end

endmodule

### rtl/lapsh_out_queue.sv
// Four-word result queue taking up to two words a cycle.
// Depends on lapsh_pkg for rsp_type and push_type.
`timescale 1ns / 1ps

module lapsh_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  lapsh_pkg::push_type push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lapsh_pkg::rsp_type  rsp_payload
);

   import lapsh_pkg::*;

   rsp_type    slot_ff [4];
   logic [1:0] wr_ptr_ff;
   logic [1:0] wr_ptr_in;
   logic [1:0] rd_ptr_ff;
   logic [1:0] rd_ptr_in;
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic       pop;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_payload = slot_ff[rd_ptr_ff];
   // Room for a full pair regardless of what drains this cycle.
   assign room        = (count_ff <= 3'd2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_ff + 2'd1] <= push.slot1;
      end
   end

endmodule

### rtl/laplacian_sharpen_3x3_top.sv
// 3x3 Laplacian sharpening of a raster pixel stream with border pass-through.
// A pixel is registered in the working stage; its words reach rsp via the result queue.
// Throughput: one pixel per cycle; a pixel yielding two words takes two queue
// slots, and req_ready drops while a held pixel finds fewer than two of four free.
// Reset (synchronous): position, taps and queue clear, registers 640/480/1;
// line stores keep their contents. Depends on lapsh_pkg and the rtl/ modules.
`timescale 1ns / 1ps

module laplacian_sharpen_3x3_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lapsh_pkg::req_type           req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lapsh_pkg::rsp_type           rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lapsh_pkg::CSR_AW-1:0] paddr,
   input  logic [lapsh_pkg::CSR_DW-1:0] pwdata,
   output logic [lapsh_pkg::CSR_DW-1:0] prdata,
   output logic                         pready
);

   import lapsh_pkg::*;

   // Configuration registers.
   logic [FW_W-1:0]  frame_width_ff;
   logic [FH_W-1:0]  frame_height_ff;
   logic             round_mode_ff;
   reg_index_type    csr_index;
   logic [FW_W-1:0]  width;
   logic [FH_W-1:0]  height;

   // Position of the next pixel.
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [FW_W-1:0]  col_ext;
   logic [FH_W-1:0]  row_ext;
   logic [FW_W-1:0]  col_nx;
   logic [FH_W-1:0]  row_nx;
   logic             cur_interior;
   logic             cur_border;

   // Working stage.
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_px_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_interior_ff;
   logic             s1_border_ff;

   // Window taps around the centre pixel.
   logic [PIX_W-1:0] tap_left_ff;
   logic [PIX_W-1:0] tap_up_ff;
   logic [PIX_W-1:0] tap_mid_ff;
   logic [PIX_W-1:0] tap_down_ff;

   logic [PIX_W-1:0] upper_rd;
   logic [PIX_W-1:0] lower_rd;
   logic             accept;
   logic             advance;
   logic             room;
   push_type         kernel_push;
   push_type         push;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_RESET;
         frame_height_ff <= FH_RESET;
         round_mode_ff   <= 1'b1;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= pwdata[FH_W-1:0];
            REG_ROUND_MODE:   round_mode_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FRAME_WIDTH:  prdata = {{(CSR_DW-FW_W){1'b0}}, frame_width_ff};
         REG_FRAME_HEIGHT: prdata = {{(CSR_DW-FH_W){1'b0}}, frame_height_ff};
         REG_ROUND_MODE:   prdata = {{(CSR_DW-1){1'b0}}, round_mode_ff};
         default:          prdata = '0;
      endcase
   end

   // Saturate geometry to the legal range.
   always_comb begin
      priority if (frame_width_ff < FW_MIN) begin
         width = FW_MIN;
      end else if (frame_width_ff > FW_MAX) begin
         width = FW_MAX;
      end else begin
         width = frame_width_ff;
      end
      priority if (frame_height_ff < FH_MIN) begin
         height = FH_MIN;
      end else if (frame_height_ff > FH_MAX) begin
         height = FH_MAX;
      end else begin
         height = frame_height_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Position tracking for the incoming pixel
   // ---------------------------------------------------------------------
   assign advance   = s1_valid_ff && room;
   assign req_ready = !s1_valid_ff || room;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_ext = req_payload.frame_start ? '0 : {1'b0, col_ff};
      row_ext = req_payload.frame_start ? '0 : {1'b0, row_ff};
      // Wrap a position left outside a shrunken frame.
      if (col_ext >= width) begin
         col_ext = '0;
         row_ext = row_ext + FH_W'(1);
      end
      if (row_ext >= height) begin
         row_ext = '0;
      end

      cur_interior = (row_ext >= FH_W'(2)) && (col_ext >= FW_W'(2));
      cur_border   = (row_ext == '0) || (row_ext == height - FH_W'(1)) ||
                     (col_ext == '0) || (col_ext == width - FW_W'(1));

      col_nx = col_ext + FW_W'(1);
      row_nx = row_ext;
      if (col_nx >= width) begin
         col_nx = '0;
         row_nx = row_nx + FH_W'(1);
         if (row_nx >= height) begin
            row_nx = '0;
         end
      end
      col_in = col_nx[COL_W-1:0];
      row_in = row_nx[ROW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= req_payload.pixel_in;
         s1_row_ff      <= row_ext[ROW_W-1:0];
         s1_col_ff      <= col_ext[COL_W-1:0];
         s1_interior_ff <= cur_interior;
         s1_border_ff   <= cur_border;
      end
   end

   // ---------------------------------------------------------------------
   // Line stores: upper holds row r-2, lower holds row r-1
   // ---------------------------------------------------------------------
   lapsh_line_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIX_W)
   ) u_upper (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data (lower_rd),
      .rd_en   (accept),
      .rd_addr (col_ext[COL_W-1:0]),
      .rd_data (upper_rd)
   );

   lapsh_line_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIX_W)
   ) u_lower (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_ext[COL_W-1:0]),
      .rd_data (lower_rd)
   );

   // Shift the window one column as the pixel leaves the working stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_left_ff <= '0;
         tap_up_ff   <= '0;
         tap_mid_ff  <= '0;
         tap_down_ff <= '0;
      end else if (advance) begin
         tap_left_ff <= tap_mid_ff;
         tap_up_ff   <= upper_rd;
         tap_mid_ff  <= lower_rd;
         tap_down_ff <= s1_px_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Arithmetic and result queue
   // ---------------------------------------------------------------------
   lapsh_kernel u_kernel (
      .up         (tap_up_ff),
      .left       (tap_left_ff),
      .mid        (tap_mid_ff),
      .right      (lower_rd),
      .down       (tap_down_ff),
      .round_mode (round_mode_ff),
      .pixel      (s1_px_ff),
      .row        (s1_row_ff),
      .col        (s1_col_ff),
      .interior   (s1_interior_ff),
      .border     (s1_border_ff),
      .push       (kernel_push)
   );

   always_comb begin
      push = kernel_push;
      if (!advance) begin
         push.count = 2'd0;
      end
   end

   lapsh_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### tb/sv/laplacian_sharpen_3x3_top_tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for laplacian_sharpen_3x3_top: streams frames of several
// geometries, predicts every output word and compares it field by field.
// Depends on lapsh_pkg and the RTL top level only.

module laplacian_sharpen_3x3_top_tb;
   import lapsh_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 80;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_payload;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count    = 0;
   int stall_cycles  = 0;

   // Predictor state: configuration, line stores, window and raster position
   logic [FW_W-1:0]  cfg_width;
   logic [FH_W-1:0]  cfg_height;
   logic             cfg_round;
   logic [PIX_W-1:0] upper_line [MAX_WIDTH];
   logic [PIX_W-1:0] lower_line [MAX_WIDTH];
   logic [PIX_W-1:0] taps [6];
   int unsigned      pos_row;
   int unsigned      pos_col;
   rsp_type          expected_words [$];

   laplacian_sharpen_3x3_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      $display("%0t: MISMATCH %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [11:0] got, logic [11:0] want, rsp_type at);
      if (got !== want) begin
         report_mismatch($sformatf("%s of word at row %0d col %0d: got %0d, expected %0d",
                                   name, at.out_row, at.out_col, got, want));
      end
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [PIX_W-1:0] sharpened(int up, int left, int mid, int right,
                                                  int down);
      int sum;
      int quot;
      sum = 8 * mid - up - left - right - down;
      if (sum < 0) return '0;
      quot = sum / 4;
      if (cfg_round && sum % 4 == 3) quot++;
      if (quot > 255) quot = 255;
      return PIX_W'(quot);
   endfunction

   function automatic rsp_type make_word(logic [PIX_W-1:0] px, int unsigned row,
                                         int unsigned col, logic border);
      rsp_type word;
      word.pixel_out   = px;
      word.out_row     = ROW_W'(row);
      word.out_col     = COL_W'(col);
      word.is_border   = border;
      word.last_of_run = 1'b0;
      return word;
   endfunction

   // Work out the words one accepted pixel causes and queue them.
   task automatic predict_pixel(req_type word);
      int unsigned      w;
      int unsigned      h;
      int unsigned      r;
      int unsigned      c;
      int               n;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] lo;
      rsp_type          words [2];
      w = clamp_dim(32'(cfg_width), MAX_WIDTH);
      h = clamp_dim(32'(cfg_height), MAX_HEIGHT);
      n = 0;
      if (word.frame_start) begin
         pos_row = 0;
         pos_col = 0;
      end
      // geometry may have shrunk under the stored position
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      if (pos_row >= h) pos_row = 0;
      r  = pos_row;
      c  = pos_col;
      up = upper_line[c];
      lo = lower_line[c];
      if (r >= 2 && c >= 2) begin
         words[n] = make_word(sharpened(int'(taps[3]), int'(taps[1]), int'(taps[4]),
                                        int'(lo), int'(taps[5])),
                              r - 1, c - 1, 1'b0);
         n++;
      end
      if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
         words[n] = make_word(word.pixel_in, r, c, 1'b1);
         n++;
      end
      if (n > 0) words[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_words.push_back(words[i]);

      taps[0] = taps[3];
      taps[1] = taps[4];
      taps[2] = taps[5];
      taps[3] = up;
      taps[4] = lo;
      taps[5] = word.pixel_in;
      upper_line[c] = lo;
      lower_line[c] = word.pixel_in;

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      pos_row = r;
      pos_col = c;
   endtask

   function automatic logic at_frame_origin();
      int unsigned r;
      int unsigned c;
      r = pos_row;
      c = pos_col;
      if (c >= clamp_dim(32'(cfg_width), MAX_WIDTH)) begin
         c = 0;
         r++;
      end
      if (r >= clamp_dim(32'(cfg_height), MAX_HEIGHT)) r = 0;
      return r == 0 && c == 0;
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixel(logic [PIX_W-1:0] px, logic fs);
      req_type word;
      word.pixel_in    = px;
      word.frame_start = fs;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= word;
      do @(posedge clock); while (!req_ready);
      predict_pixel(word);
   endtask

   // Drop valid and let every outstanding word drain before touching registers.
   task automatic drain_results(int extra_cycles);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_FRAME_WIDTH:  cfg_width  = value[FW_W-1:0];
         REG_FRAME_HEIGHT: cfg_height = value[FH_W-1:0];
         REG_ROUND_MODE:   cfg_round  = value[0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(reg_index_type idx, logic [CSR_DW-1:0] want);
      logic [CSR_DW-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== want) begin
         report_mismatch($sformatf("register %s: read %0d, expected %0d",
                                   idx.name(), got, want));
      end
   endtask

   task automatic program_frame(logic [FW_W-1:0] w, logic [FH_W-1:0] h, logic rnd);
      drain_results(6);
      write_register(REG_FRAME_WIDTH, CSR_DW'(w));
      write_register(REG_FRAME_HEIGHT, CSR_DW'(h));
      write_register(REG_ROUND_MODE, CSR_DW'(rnd));
      check_register(REG_FRAME_WIDTH, CSR_DW'(w));
      check_register(REG_FRAME_HEIGHT, CSR_DW'(h));
      check_register(REG_ROUND_MODE, CSR_DW'(rnd));
   endtask

   task automatic test_register_reset();
      check_register(REG_FRAME_WIDTH, CSR_DW'(FW_RESET));
      check_register(REG_FRAME_HEIGHT, CSR_DW'(FH_RESET));
      check_register(REG_ROUND_MODE, CSR_DW'(1));
      write_register(REG_UNUSED, CSR_DW'($urandom()));
   endtask

   // Oversized width saturates to the full line; run one row and step into the next.
   task automatic test_widest_frame();
      program_frame(11'd2047, 13'd0, 1'b1);
      for (int i = 0; i < MAX_WIDTH + 16; i++) send_pixel(pick_pixel(), i == 0);
   endtask

   // Bright centre saturates, its dark neighbour goes negative and clamps to zero.
   task automatic test_clamping();
      logic [PIX_W-1:0] pixels [12];
      pixels = '{8'd0, 8'd0,   8'd0, 8'd0,
                 8'd0, 8'd255, 8'd0, 8'd0,
                 8'd0, 8'd0,   8'd0, 8'd0};
      program_frame(11'd4, 13'd2, 1'b1);
      for (int i = 0; i < 12; i++) send_pixel(pixels[i], i == 0);
   endtask

   // Remainder of three with rounding off; the frame starts by wrapping, not by flag.
   task automatic test_rounding();
      logic [PIX_W-1:0] pixels [12];
      pixels = '{8'd0, 8'd1,   8'd2,   8'd0,
                 8'd0, 8'd100, 8'd101, 8'd0,
                 8'd0, 8'd3,   8'd0,   8'd0};
      program_frame(11'd4, 13'd2, 1'b0);
      for (int i = 0; i < 12; i++) send_pixel(pixels[i], 1'b0);
   endtask

   // Mostly well-formed frames with random content, plus stray frame starts.
   // A wider line opens a fresh frame so no unwritten store entry is read.
   task automatic test_random_stream(logic [FW_W-1:0] w, logic [FH_W-1:0] h, logic rnd);
      logic        fs;
      int unsigned old_w;
      old_w = clamp_dim(32'(cfg_width), MAX_WIDTH);
      program_frame(w, h, rnd);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 0 && clamp_dim(32'(cfg_width), MAX_WIDTH) > old_w) begin
            fs = 1'b1;
         end else if (at_frame_origin()) begin
            fs = ($urandom_range(9) != 0);
         end else begin
            fs = ($urandom_range(49) == 0);
         end
         send_pixel(pick_pixel(), fs);
      end
   endtask

   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word with nothing expected: row %0d col %0d pixel %0d",
                                      rsp_payload.out_row, rsp_payload.out_col,
                                      rsp_payload.pixel_out));
         end else begin
            want = expected_words.pop_front();
            check_field("pixel_out", 12'(rsp_payload.pixel_out), 12'(want.pixel_out), want);
            check_field("out_row", rsp_payload.out_row, want.out_row, want);
            check_field("out_col", 12'(rsp_payload.out_col), 12'(want.out_col), want);
            check_field("is_border", 12'(rsp_payload.is_border), 12'(want.is_border), want);
            check_field("last_of_run", 12'(rsp_payload.last_of_run),
                        12'(want.last_of_run), want);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      req_valid   <= 1'b0;
      req_payload <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      reset       <= 1'b1;
      cfg_width  = FW_RESET;
      cfg_height = FH_RESET;
      cfg_round  = 1'b1;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (lower_line[i]) lower_line[i] = '0;
      foreach (taps[i]) taps[i] = '0;
      pos_row = 0;
      pos_col = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_idling(20, 79);
      test_register_reset();
      test_widest_frame();
      test_clamping();
      test_rounding();
      test_random_stream(11'd0, 13'd8191, 1'b0);
      test_random_stream(11'd6, 13'd5, 1'b1);
      set_idling(79, 20);
      test_random_stream(11'd17, 13'd4, 1'b1);
      test_random_stream(11'd1, 13'd9, 1'b0);
      set_idling(0, 0);
      test_random_stream(11'd31, 13'd7, 1'b1);
      test_random_stream(11'd1024, 13'd4096, 1'b0);
      test_random_stream(11'd10, 13'd3, 1'b1);
      drain_results(10);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### laplacian_sharpen_3x3_top.f
rtl/lapsh_pkg.sv
rtl/lapsh_line_ram.sv
rtl/lapsh_kernel.sv
rtl/lapsh_out_queue.sv
rtl/laplacian_sharpen_3x3_top.sv
tb/sv/laplacian_sharpen_3x3_top_tb.sv
